@@ sv/aip_pkg.sv @@
package aip_pkg;

    localparam int COUNT_WIDTH    = 16;
    localparam int VALUE_WIDTH    = 64;
    localparam int CONSUMED_WIDTH = 16;
    localparam int CFG_INDEX_WIDTH = 3;

    typedef enum logic [1:0] {
        RADIX_UDEC = 2'd0,
        RADIX_SDEC = 2'd1,
        RADIX_HEX  = 2'd2,
        RADIX_BIN  = 2'd3
    } radix_mode_t;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RADIX_MODE  = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_WIDE_MODE   = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_WRAP_ENABLE = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ALLOW_PLUS  = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ERROR_VALUE = 3'd4;

    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_ONE     = 8'h31;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_F = 8'h66;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;

    localparam logic [VALUE_WIDTH-1:0] MASK_WIDE   = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [VALUE_WIDTH-1:0] MASK_NARROW = 64'h0000_0000_FFFF_FFFF;

    localparam logic [VALUE_WIDTH-1:0] DEC_LIM_WIDE    = MASK_WIDE / 10;
    localparam logic [VALUE_WIDTH-1:0] DEC_LIM_NARROW  = MASK_NARROW / 10;
    localparam logic [VALUE_WIDTH-1:0] SDEC_LIM_WIDE   = (MASK_WIDE >> 1) / 10;
    localparam logic [VALUE_WIDTH-1:0] SDEC_LIM_NARROW = (MASK_NARROW >> 1) / 10;
    localparam logic [VALUE_WIDTH-1:0] HEX_LIM_WIDE    = MASK_WIDE / 16;
    localparam logic [VALUE_WIDTH-1:0] HEX_LIM_NARROW  = MASK_NARROW / 16;
    localparam logic [VALUE_WIDTH-1:0] BIN_LIM_WIDE    = MASK_WIDE / 2;
    localparam logic [VALUE_WIDTH-1:0] BIN_LIM_NARROW  = MASK_NARROW / 2;

    localparam logic [3:0] DEC_LAST  = 4'd5;
    localparam logic [3:0] SDEC_LAST = 4'd8;
    localparam logic [3:0] HEX_LAST  = 4'd15;
    localparam logic [3:0] BIN_LAST  = 4'd1;

    typedef struct packed {
        radix_mode_t                radix_mode;
        logic                       wide_mode;
        logic                       wrap_enable;
        logic                       allow_plus;
        logic [VALUE_WIDTH-1:0]     error_value;
    } cfg_t;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0]     value_bits;
        logic                       ok;
        logic                       overflow_flag;
        logic [CONSUMED_WIDTH-1:0]  consumed_count;
    } result_t;

endpackage

@@ sv/aip_digit_decode.sv @@
module aip_digit_decode
(
    input  logic [7:0]          char_byte,
    input  aip_pkg::radix_mode_t radix_mode,
    output logic                digit_valid,
    output logic [3:0]          digit_value
);

    logic [7:0] off_zero;
    logic [7:0] off_upper;
    logic [7:0] off_lower;
    logic       is_dec;
    logic       is_upper;
    logic       is_lower;

    always_comb
    begin
        off_zero  = char_byte - aip_pkg::CHAR_ZERO;
        off_upper = char_byte - aip_pkg::CHAR_UPPER_A;
        off_lower = char_byte - aip_pkg::CHAR_LOWER_A;
        is_dec    = (char_byte >= aip_pkg::CHAR_ZERO) && (char_byte <= aip_pkg::CHAR_NINE);
        is_upper  = (char_byte >= aip_pkg::CHAR_UPPER_A) &&
                    (char_byte <= aip_pkg::CHAR_UPPER_F);
        is_lower  = (char_byte >= aip_pkg::CHAR_LOWER_A) &&
                    (char_byte <= aip_pkg::CHAR_LOWER_F);
        digit_valid = 1'b0;
        digit_value = 4'd0;
        case (radix_mode)
            aip_pkg::RADIX_HEX:
            begin
                if (is_dec)
                begin
                    digit_valid = 1'b1;
                    digit_value = off_zero[3:0];
                end
                else if (is_upper)
                begin
                    digit_valid = 1'b1;
                    digit_value = 4'd10 + off_upper[3:0];
                end
                else if (is_lower)
                begin
                    digit_valid = 1'b1;
                    digit_value = 4'd10 + off_lower[3:0];
                end
            end
            aip_pkg::RADIX_BIN:
            begin
                if ((char_byte >= aip_pkg::CHAR_ZERO) && (char_byte <= aip_pkg::CHAR_ONE))
                begin
                    digit_valid = 1'b1;
                    digit_value = off_zero[3:0];
                end
            end
            default:
            begin
                if (is_dec)
                begin
                    digit_valid = 1'b1;
                    digit_value = off_zero[3:0];
                end
            end
        endcase
    end

endmodule

@@ sv/aip_field_core.sv @@
module aip_field_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           char_byte,
    input  logic                 start_req,
    input  aip_pkg::cfg_t        cfg,
    output logic                 emit,
    output aip_pkg::result_t     result
);

    logic [aip_pkg::VALUE_WIDTH-1:0] acc_reg;
    logic [aip_pkg::VALUE_WIDTH-1:0] acc_next;
    logic                            neg_reg;
    logic                            neg_next;
    logic                            digit_seen_reg;
    logic                            digit_seen_next;
    logic                            ovf_reg;
    logic                            ovf_next;
    logic                            active_reg;
    logic                            active_next;
    logic [aip_pkg::COUNT_WIDTH-1:0] count_reg;
    logic [aip_pkg::COUNT_WIDTH-1:0] count_next;

    logic                            digit_valid;
    logic [3:0]                      digit_value;

    logic [aip_pkg::VALUE_WIDTH-1:0] eff_acc;
    logic                            eff_neg;
    logic                            eff_digit;
    logic                            eff_ovf;
    logic                            eff_active;
    logic [aip_pkg::COUNT_WIDTH-1:0] eff_count;
    logic [aip_pkg::COUNT_WIDTH-1:0] count_inc;
    logic [31:0]                     count_ext;

    logic [aip_pkg::VALUE_WIDTH-1:0] mask;
    logic [aip_pkg::VALUE_WIDTH-1:0] n;
    logic [aip_pkg::VALUE_WIDTH-1:0] lim;
    logic [3:0]                      last;
    logic [aip_pkg::VALUE_WIDTH-1:0] prod;
    logic [aip_pkg::VALUE_WIDTH-1:0] absmin;
    logic                            over_step;
    logic                            is_signed;
    logic                            sign_byte;
    logic                            ovf_final;
    logic                            use_fail;

    aip_digit_decode u_decode
    (
        .char_byte   (char_byte),
        .radix_mode  (cfg.radix_mode),
        .digit_valid (digit_valid),
        .digit_value (digit_value)
    );

    always_comb
    begin
        eff_acc    = start_req ? '0 : acc_reg;
        eff_neg    = start_req ? 1'b0 : neg_reg;
        eff_digit  = start_req ? 1'b0 : digit_seen_reg;
        eff_ovf    = start_req ? 1'b0 : ovf_reg;
        eff_active = start_req ? 1'b1 : active_reg;
        eff_count  = start_req ? '0 : count_reg;
        count_inc  = (eff_count != '1) ? eff_count + 1'b1 : eff_count;
        count_ext  = 32'(eff_count);

        mask      = cfg.wide_mode ? aip_pkg::MASK_WIDE : aip_pkg::MASK_NARROW;
        n         = eff_acc & mask;
        is_signed = (cfg.radix_mode == aip_pkg::RADIX_SDEC);
        absmin    = (mask >> 1) + 64'd1;
        sign_byte = is_signed && (eff_count == '0) && !eff_digit &&
                    ((char_byte == aip_pkg::CHAR_MINUS) ||
                     (cfg.allow_plus && (char_byte == aip_pkg::CHAR_PLUS)));

        case (cfg.radix_mode)
            aip_pkg::RADIX_SDEC:
            begin
                lim  = cfg.wide_mode ? aip_pkg::SDEC_LIM_WIDE : aip_pkg::SDEC_LIM_NARROW;
                last = aip_pkg::SDEC_LAST;
                prod = (n << 3) + (n << 1);
            end
            aip_pkg::RADIX_HEX:
            begin
                lim  = cfg.wide_mode ? aip_pkg::HEX_LIM_WIDE : aip_pkg::HEX_LIM_NARROW;
                last = aip_pkg::HEX_LAST;
                prod = n << 4;
            end
            aip_pkg::RADIX_BIN:
            begin
                lim  = cfg.wide_mode ? aip_pkg::BIN_LIM_WIDE : aip_pkg::BIN_LIM_NARROW;
                last = aip_pkg::BIN_LAST;
                prod = n << 1;
            end
            default:
            begin
                lim  = cfg.wide_mode ? aip_pkg::DEC_LIM_WIDE : aip_pkg::DEC_LIM_NARROW;
                last = aip_pkg::DEC_LAST;
                prod = (n << 3) + (n << 1);
            end
        endcase
        prod      = (prod + {60'd0, digit_value}) & mask;
        over_step = (n > lim) || ((n == lim) && (digit_value > last));

        ovf_final = eff_ovf || (is_signed && !eff_neg && (n == absmin));
        if (is_signed)
        begin
            use_fail = !eff_digit || ovf_final;
        end
        else
        begin
            use_fail = !eff_digit || (eff_ovf && !cfg.wrap_enable);
        end

        if (use_fail)
        begin
            result.value_bits = cfg.error_value & mask;
        end
        else if (is_signed && eff_neg)
        begin
            result.value_bits = (64'd0 - n) & mask;
        end
        else
        begin
            result.value_bits = n;
        end
        result.ok             = eff_digit && !ovf_final;
        result.overflow_flag  = is_signed ? ovf_final : eff_ovf;
        result.consumed_count = count_ext[aip_pkg::CONSUMED_WIDTH-1:0];

        emit = eff_active && !sign_byte && !digit_valid;

        acc_next        = eff_acc;
        neg_next        = eff_neg;
        digit_seen_next = eff_digit;
        ovf_next        = eff_ovf;
        active_next     = eff_active;
        count_next      = eff_count;
        if (eff_active)
        begin
            if (sign_byte)
            begin
                neg_next   = (char_byte == aip_pkg::CHAR_MINUS);
                count_next = count_inc;
            end
            else if (digit_valid)
            begin
                count_next      = count_inc;
                digit_seen_next = 1'b1;
                if (is_signed)
                begin
                    if (!eff_ovf)
                    begin
                        ovf_next = over_step;
                        acc_next = prod;
                    end
                end
                else
                begin
                    ovf_next = eff_ovf || over_step;
                    acc_next = prod;
                end
            end
            else
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg        <= '0;
            neg_reg        <= 1'b0;
            digit_seen_reg <= 1'b0;
            ovf_reg        <= 1'b0;
            active_reg     <= 1'b0;
            count_reg      <= '0;
        end
        else if (step)
        begin
            acc_reg        <= acc_next;
            neg_reg        <= neg_next;
            digit_seen_reg <= digit_seen_next;
            ovf_reg        <= ovf_next;
            active_reg     <= active_next;
            count_reg      <= count_next;
        end
    end

endmodule

@@ sv/ascii_integer_parser.sv @@
// Parses ASCII integer fields from a byte stream at one byte per clock cycle, sustained, in
// every radix and width: a beat taken on the input is registered, and once it advances the
// field state (accumulator, sign, digit and overflow flags, byte count) is updated by one
// constant-radix shift-add with a parallel limit compare, which is the loop that sets the
// one-cycle rate. A field's result beat is captured in the output register once its
// terminating byte has passed the input register, and waits there while further bytes keep
// flowing in; only a second terminator behind an untaken result stalls the input.
// Configuration writes take effect at once and are meant to be made while no byte is in
// flight.
module ascii_integer_parser
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [aip_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [aip_pkg::VALUE_WIDTH-1:0]      cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [7:0]                           char_byte,
    input  logic                                 start_req,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [aip_pkg::VALUE_WIDTH-1:0]      value_bits,
    output logic                                 ok,
    output logic                                 overflow_flag,
    output logic [aip_pkg::CONSUMED_WIDTH-1:0]   consumed_count
);

    aip_pkg::cfg_t    cfg_reg;
    logic             in_valid_reg;
    logic [7:0]       char_reg;
    logic             start_reg;
    logic             out_valid_reg;
    aip_pkg::result_t result_reg;

    logic             emit;
    logic             advance;
    aip_pkg::result_t result;

    aip_field_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .char_byte (char_reg),
        .start_req (start_reg),
        .cfg       (cfg_reg),
        .emit      (emit),
        .result    (result)
    );

    assign advance  = in_valid_reg && (!emit || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.radix_mode  <= aip_pkg::RADIX_UDEC;
            cfg_reg.wide_mode   <= 1'b1;
            cfg_reg.wrap_enable <= 1'b0;
            cfg_reg.allow_plus  <= 1'b0;
            cfg_reg.error_value <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                aip_pkg::CFG_RADIX_MODE:
                    cfg_reg.radix_mode <= aip_pkg::radix_mode_t'(cfg_data[1:0]);
                aip_pkg::CFG_WIDE_MODE:   cfg_reg.wide_mode   <= cfg_data[0];
                aip_pkg::CFG_WRAP_ENABLE: cfg_reg.wrap_enable <= cfg_data[0];
                aip_pkg::CFG_ALLOW_PLUS:  cfg_reg.allow_plus  <= cfg_data[0];
                aip_pkg::CFG_ERROR_VALUE: cfg_reg.error_value <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            char_reg  <= char_byte;
            start_reg <= start_req;
        end
        if (advance && emit)
        begin
            result_reg <= result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign value_bits     = result_reg.value_bits;
    assign ok             = result_reg.ok;
    assign overflow_flag  = result_reg.overflow_flag;
    assign consumed_count = result_reg.consumed_count;

endmodule

@@ tb/sv/aip_result_checker.sv @@
module aip_result_checker
    import aip_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [VALUE_WIDTH-1:0]      cfg_data,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [7:0]                  char_byte,
    input  logic                        start_req,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [VALUE_WIDTH-1:0]      value_bits,
    input  logic                        ok,
    input  logic                        overflow_flag,
    input  logic [CONSUMED_WIDTH-1:0]   consumed_count,
    output int                          error_count,
    output int                          results_pending
);

    radix_mode_t                cfg_mode;
    logic                       cfg_wide;
    logic                       cfg_wrap;
    logic                       cfg_plus;
    logic [VALUE_WIDTH-1:0]     cfg_fail;

    logic [VALUE_WIDTH-1:0]     acc;
    logic                       neg_seen;
    logic                       digit_seen;
    logic                       ovf;
    logic                       field_open;
    logic [COUNT_WIDTH-1:0]     field_len;

    result_t                    parsed_fields[$];
    result_t                    next_result;
    result_t                    oldest;
    logic                       mismatch;

    function automatic logic parse_beat(input logic [7:0] c, input logic first,
                                        output result_t res);
        logic [VALUE_WIDTH-1:0] mask;
        logic [VALUE_WIDTH-1:0] n;
        logic [VALUE_WIDTH-1:0] radix;
        logic [VALUE_WIDTH-1:0] d;
        logic [VALUE_WIDTH-1:0] lim;
        logic [VALUE_WIDTH-1:0] absmin;
        logic [VALUE_WIDTH-1:0] val;
        logic                   is_digit;
        res = '0;
        if (first)
        begin
            acc        = '0;
            neg_seen   = 1'b0;
            digit_seen = 1'b0;
            ovf        = 1'b0;
            field_open = 1'b1;
            field_len  = '0;
        end
        if (!field_open)
            return 1'b0;
        mask   = cfg_wide ? MASK_WIDE : MASK_NARROW;
        n      = acc & mask;
        absmin = (mask >> 1) + 64'd1;

        if (cfg_mode == RADIX_SDEC && field_len == '0 && !digit_seen &&
            (c == CHAR_MINUS || (cfg_plus && c == CHAR_PLUS)))
        begin
            neg_seen = (c == CHAR_MINUS);
            if (field_len != '1)
                field_len = field_len + 1'b1;
            return 1'b0;
        end

        is_digit = 1'b0;
        d        = '0;
        radix    = 64'd10;
        if (cfg_mode == RADIX_BIN)
        begin
            radix = 64'd2;
            if (c >= CHAR_ZERO && c <= CHAR_ONE)
            begin
                d        = 64'(c - CHAR_ZERO);
                is_digit = 1'b1;
            end
        end
        else if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            d        = 64'(c - CHAR_ZERO);
            is_digit = 1'b1;
        end
        if (cfg_mode == RADIX_HEX)
        begin
            radix = 64'd16;
            if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F)
            begin
                d        = 64'(c - CHAR_UPPER_A) + 64'd10;
                is_digit = 1'b1;
            end
            else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F)
            begin
                d        = 64'(c - CHAR_LOWER_A) + 64'd10;
                is_digit = 1'b1;
            end
        end

        if (is_digit)
        begin
            if (field_len != '1)
                field_len = field_len + 1'b1;
            digit_seen = 1'b1;
            if (cfg_mode == RADIX_SDEC)
            begin
                if (!ovf)
                begin
                    lim = (mask >> 1) / 64'd10;
                    if (n > lim || (n == lim && d > absmin % 64'd10))
                        ovf = 1'b1;
                    acc = (n * 64'd10 + d) & mask;
                end
            end
            else
            begin
                lim = mask / radix;
                if (n > lim || (n == lim && d > mask % radix))
                    ovf = 1'b1;
                acc = (n * radix + d) & mask;
            end
            return 1'b0;
        end

        if (cfg_mode == RADIX_SDEC)
        begin
            if (!ovf && !neg_seen && n == absmin)
                ovf = 1'b1;
            if (!digit_seen || ovf)
                val = cfg_fail & mask;
            else if (n == absmin)
                val = absmin;
            else if (neg_seen)
                val = (64'd0 - n) & mask;
            else
                val = n;
        end
        else if (!digit_seen || (ovf && !cfg_wrap))
            val = cfg_fail & mask;
        else
            val = n;

        res.value_bits     = val;
        res.ok             = digit_seen && !ovf;
        res.overflow_flag  = ovf;
        res.consumed_count = field_len;
        field_open         = 1'b0;
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_mode   = RADIX_UDEC;
            cfg_wide   = 1'b1;
            cfg_wrap   = 1'b0;
            cfg_plus   = 1'b0;
            cfg_fail   = '0;
            acc        = '0;
            neg_seen   = 1'b0;
            digit_seen = 1'b0;
            ovf        = 1'b0;
            field_open = 1'b0;
            field_len  = '0;
            parsed_fields.delete();
            error_count     <= 0;
            results_pending <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (parsed_fields.size() == 0)
                begin
                    $display("%0t: result beat with none expected, actual %h ok %b ovf %b %s %0d",
                             $time, value_bits, ok, overflow_flag, "count", consumed_count);
                    error_count <= error_count + 1;
                end
                else
                begin
                    oldest   = parsed_fields.pop_front();
                    mismatch = 1'b0;
                    if (value_bits !== oldest.value_bits)
                    begin
                        $display("%0t: value_bits expected %h actual %h",
                                 $time, oldest.value_bits, value_bits);
                        mismatch = 1'b1;
                    end
                    if (ok !== oldest.ok)
                    begin
                        $display("%0t: ok expected %b actual %b", $time, oldest.ok, ok);
                        mismatch = 1'b1;
                    end
                    if (overflow_flag !== oldest.overflow_flag)
                    begin
                        $display("%0t: overflow_flag expected %b actual %b",
                                 $time, oldest.overflow_flag, overflow_flag);
                        mismatch = 1'b1;
                    end
                    if (consumed_count !== oldest.consumed_count)
                    begin
                        $display("%0t: consumed_count expected %0d actual %0d",
                                 $time, oldest.consumed_count, consumed_count);
                        mismatch = 1'b1;
                    end
                    if (mismatch)
                        error_count <= error_count + 1;
                end
            end
            if (in_valid && in_ready)
            begin
                if (parse_beat(char_byte, start_req, next_result))
                    parsed_fields.push_back(next_result);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RADIX_MODE:  cfg_mode = radix_mode_t'(cfg_data[1:0]);
                    CFG_WIDE_MODE:   cfg_wide = cfg_data[0];
                    CFG_WRAP_ENABLE: cfg_wrap = cfg_data[0];
                    CFG_ALLOW_PLUS:  cfg_plus = cfg_data[0];
                    CFG_ERROR_VALUE: cfg_fail = cfg_data;
                    default:         ;
                endcase
            end
            results_pending <= parsed_fields.size();
        end
    end

endmodule

@@ tb/sv/ascii_integer_parser_tb.sv @@
module ascii_integer_parser_tb;

    import aip_pkg::*;

    localparam int CYCLE_LIMIT      = 200000;
    localparam int DRAIN_CYCLES     = 4;
    localparam int LONG_HOLD_CYCLES = 150;
    localparam int RANDOM_PHASES    = 14;
    localparam int PHASE_BYTES      = 80;
    localparam int HOLD_PHASE       = 5;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [VALUE_WIDTH-1:0]     cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [7:0]                 char_byte = '0;
    logic                       start_req = 1'b0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [VALUE_WIDTH-1:0]     value_bits;
    logic                       ok;
    logic                       overflow_flag;
    logic [CONSUMED_WIDTH-1:0]  consumed_count;

    int                         error_count;
    int                         results_pending;
    int                         cycle_count = 0;
    logic                       quiet = 1'b0;
    logic                       long_hold_pending = 1'b0;
    radix_mode_t                cur_mode = RADIX_UDEC;
    logic                       cur_wide = 1'b1;
    logic [7:0]                 field_text[$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    ascii_integer_parser i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .char_byte      (char_byte),
        .start_req      (start_req),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .value_bits     (value_bits),
        .ok             (ok),
        .overflow_flag  (overflow_flag),
        .consumed_count (consumed_count)
    );

    aip_result_checker i_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .char_byte       (char_byte),
        .start_req       (start_req),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .value_bits      (value_bits),
        .ok              (ok),
        .overflow_flag   (overflow_flag),
        .consumed_count  (consumed_count),
        .error_count     (error_count),
        .results_pending (results_pending)
    );

    task automatic send_beat(input logic [7:0] c, input logic first);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_byte <= c;
        start_req <= first;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [VALUE_WIDTH-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic load_config(input radix_mode_t mode, input logic wide, input logic wrap,
                               input logic plus, input logic [VALUE_WIDTH-1:0] fail);
        write_reg(CFG_RADIX_MODE, {62'd0, mode});
        write_reg(CFG_WIDE_MODE, {63'd0, wide});
        write_reg(CFG_WRAP_ENABLE, {63'd0, wrap});
        write_reg(CFG_ALLOW_PLUS, {63'd0, plus});
        write_reg(CFG_ERROR_VALUE, fail);
        cfg_we   <= 1'b0;
        cur_mode  = mode;
        cur_wide  = wide;
    endtask

    function automatic void compose_field();
        logic [VALUE_WIDTH-1:0] mask;
        logic [VALUE_WIDTH-1:0] v;
        int unsigned            radix;
        int unsigned            maxlen;
        int unsigned            pick;
        logic [3:0]             digits[$];
        logic [3:0]             digit;
        logic [7:0]             t;
        field_text.delete();
        mask   = cur_wide ? MASK_WIDE : MASK_NARROW;
        radix  = (cur_mode == RADIX_HEX) ? 16 : (cur_mode == RADIX_BIN) ? 2 : 10;
        maxlen = (cur_mode == RADIX_HEX) ? (cur_wide ? 16 : 8) :
                 (cur_mode == RADIX_BIN) ? (cur_wide ? 64 : 32) : (cur_wide ? 20 : 10);

        pick = $urandom_range(0, 19);
        if (cur_mode == RADIX_SDEC)
        begin
            if (pick < 9)
                field_text.push_back(CHAR_MINUS);
            else if (pick < 12)
                field_text.push_back(CHAR_PLUS);
        end
        else if (pick == 0)
            field_text.push_back($urandom_range(0, 1) ? CHAR_MINUS : CHAR_PLUS);

        pick = $urandom_range(0, 9);
        if (pick >= 1 && pick <= 6)
        begin
            repeat ((pick <= 4) ? $urandom_range(1, 4) : $urandom_range(1, maxlen + 2))
                digits.push_back(4'($urandom_range(0, radix - 1)));
        end
        else if (pick > 6)
        begin
            case ($urandom_range(0, 4))
                0:       v = mask;
                1:       v = mask >> 1;
                2:       v = (mask >> 1) + 64'd1;
                3:       v = mask - 64'($urandom_range(0, 20));
                default: v = (mask >> 1) - 64'($urandom_range(0, 20));
            endcase
            do
            begin
                digit = 4'(v % radix);
                digits.push_front(digit);
                v = v / radix;
            end
            while (v != 0);
            case ($urandom_range(0, 2))
                0: digits.push_back(4'($urandom_range(0, radix - 1)));
                1:
                begin
                    if (digits[digits.size() - 1] < radix - 1)
                        digits[digits.size() - 1] = digits[digits.size() - 1] + 4'd1;
                end
                default: ;
            endcase
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) digits.push_front(4'd0);
        end

        foreach (digits[k])
        begin
            if (digits[k] < 4'd10)
                field_text.push_back(CHAR_ZERO + 8'(digits[k]));
            else
                field_text.push_back(($urandom_range(0, 1) ? CHAR_UPPER_A : CHAR_LOWER_A)
                                     + 8'(digits[k]) - 8'd10);
        end

        if ($urandom_range(0, 15) != 0)
        begin
            if ($urandom_range(0, 3) == 0)
                t = $urandom_range(0, 1) ? CHAR_MINUS : CHAR_PLUS;
            else
            begin
                do
                    t = 8'($urandom_range(0, 255));
                while ((t >= CHAR_ZERO && t <= ((radix == 2) ? CHAR_ONE : CHAR_NINE)) ||
                       (radix == 16 && ((t >= CHAR_UPPER_A && t <= CHAR_UPPER_F) ||
                                        (t >= CHAR_LOWER_A && t <= CHAR_LOWER_F))));
            end
            field_text.push_back(t);
        end
    endfunction

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("ascii_integer_parser_tb: errors");
        $finish;
    end

    initial
    begin
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold_pending)
            begin
                long_hold_pending = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    initial
    begin
        int                     phase;
        int                     sent;
        int                     i;
        logic [VALUE_WIDTH-1:0] fail_bits;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register values after reset: a byte while idle, a plain field, a sign that
        // ends an unsigned field, and a restart that drops an open field.
        send_beat(8'hFF, 1'b0);
        send_beat(CHAR_ZERO + 8'd7, 1'b1);
        send_beat(CHAR_ZERO + 8'd2, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(CHAR_MINUS, 1'b1);
        send_beat(CHAR_ZERO + 8'd5, 1'b1);
        send_beat(CHAR_NINE, 1'b1);
        send_beat(8'hFF, 1'b0);

        drain_results();
        load_config(RADIX_SDEC, 1'b0, 1'b1, 1'b0, '1);
        send_beat(CHAR_PLUS, 1'b1);
        send_beat(CHAR_MINUS, 1'b1);
        send_beat(CHAR_ZERO + 8'd4, 1'b0);
        send_beat(8'h20, 1'b0);
        send_beat(CHAR_MINUS, 1'b1);
        send_beat(8'h2C, 1'b0);

        drain_results();
        load_config(RADIX_SDEC, 1'b1, 1'b0, 1'b1, 64'h0123_4567_89AB_CDEF);
        send_beat(CHAR_PLUS, 1'b1);
        send_beat(CHAR_ZERO + 8'd7, 1'b0);
        send_beat(8'h3B, 1'b0);

        drain_results();
        load_config(RADIX_HEX, 1'b1, 1'b0, 1'b1, 64'hFEDC_BA98_7654_3210);
        send_beat(CHAR_LOWER_F, 1'b1);
        send_beat(CHAR_UPPER_A, 1'b0);
        send_beat(CHAR_NINE, 1'b0);
        send_beat(8'h67, 1'b0);

        // The binary field stays open across a switch to unsigned decimal.
        drain_results();
        load_config(RADIX_BIN, 1'b0, 1'b0, 1'b1, '0);
        send_beat(CHAR_ONE, 1'b1);
        send_beat(CHAR_ONE, 1'b0);
        drain_results();
        load_config(RADIX_UDEC, 1'b1, 1'b0, 1'b0, 64'hFFFF_FFFF_0000_0001);
        send_beat(CHAR_NINE, 1'b0);
        send_beat(8'h78, 1'b0);

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain_results();
            case (phase % 3)
                0:       fail_bits = '0;
                1:       fail_bits = '1;
                default: fail_bits = {$urandom, $urandom};
            endcase
            load_config(radix_mode_t'(phase[1:0]), phase[2], 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), fail_bits);
            if (phase == HOLD_PHASE)
                long_hold_pending = 1'b1;
            if (phase == RANDOM_PHASES - 1)
                quiet = 1'b1;
            sent = 0;
            while (sent < PHASE_BYTES)
            begin
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(1, 3)) send_beat(8'($urandom_range(0, 255)), 1'b0);
                compose_field();
                for (i = 0; i < field_text.size(); i++)
                    send_beat(field_text[i], i == 0);
                sent += field_text.size();
            end
        end

        drain_results();
        if (error_count == 0 && results_pending == 0)
            $display("ascii_integer_parser_tb: clean");
        else
            $display("ascii_integer_parser_tb: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/aip_pkg.sv
sv/aip_digit_decode.sv
sv/aip_field_core.sv
sv/ascii_integer_parser.sv
tb/sv/aip_result_checker.sv
tb/sv/ascii_integer_parser_tb.sv
